>>> rtl/nspb_pkg.sv
// Shared types and constants for the split-phase barrier.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package nspb_pkg;

    localparam int CNT_W = 6;
    localparam logic [CNT_W-1:0] COUNT_MAX = 6'd63;
    localparam logic [4:0] CFG_RESET = 5'd16;

    localparam logic OP_NOTIFY = 1'b0;
    localparam logic OP_WAIT   = 1'b1;

    localparam logic [1:0] FLAG_NAMED    = 2'd0;
    localparam logic [1:0] FLAG_MISMATCH = 2'd2;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_MISMATCH  = 3'd1,
        ST_NOT_READY = 3'd2,
        ST_NOTIFIED  = 3'd3,
        ST_PROTOCOL  = 3'd4
    } t_status;

    typedef struct packed {
        logic load;
        logic notify;
        logic scan_start;
        logic scan_step;
        logic depart;
    } t_cmd;

    typedef struct packed {
        logic err;
        logic op_wait;
        logic not_ready;
        logic scan_done;
        logic mismatch;
    } t_sts;

endpackage

`default_nettype wire

>>> rtl/nspb_dp.sv
// Barrier datapath: request registers, bank counters, node phase state,
// the stored flag and id memory, and the completion scan. Uses nspb_pkg.
`default_nettype none

module nspb_dp
    import nspb_pkg::*;
#(
    parameter int NODES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [4:0]  i_cfg_wdata,
    input  wire logic        i_op,
    input  wire logic [3:0]  i_node,
    input  wire logic [31:0] i_id,
    input  wire logic [1:0]  i_flags,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts
);

    localparam int NW    = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int AW    = NW + 1;
    localparam int DEPTH = 2 ** AW;

    logic [4:0]       r_cfg;
    logic             r_op;
    logic [3:0]       r_node;
    logic [31:0]      r_id;
    logic [1:0]       r_flags;
    logic [CNT_W-1:0] r_arrive [2];
    logic [CNT_W-1:0] r_depart [2];
    logic [1:0]       r_sticky;
    logic [NODES-1:0] r_phase;
    logic [NODES-1:0] r_inside;
    logic [DEPTH-1:0] r_vld;
    logic [33:0]      r_mem [DEPTH];
    logic [33:0]      r_rd_data;
    logic             r_rd_valid;
    logic             r_bank;
    logic [CNT_W-1:0] r_ridx;
    logic             r_rd_own;
    logic             r_rd_scan;
    logic             r_issuing;
    logic             r_mm;
    logic             r_has_ref;
    logic [31:0]      r_ref;

    logic [4:0]       eff_n;
    logic [CNT_W-1:0] eff_n_w;
    logic [NW-1:0]    node_idx;
    logic             cur_bank;
    logic             cur_inside;
    logic             in_range;
    logic             issue_scan;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [1:0]       rd_flags;
    logic [31:0]      rd_id;
    logic [CNT_W-1:0] n_depart;

    always_comb begin
        if (r_cfg == 5'd0) begin
            eff_n = 5'd1;
        end else if (int'(r_cfg) > NODES) begin
            eff_n = 5'(NODES);
        end else begin
            eff_n = r_cfg;
        end
    end

    assign eff_n_w    = CNT_W'(eff_n);
    assign node_idx   = NW'(r_node);
    assign cur_bank   = r_phase[node_idx];
    assign cur_inside = r_inside[node_idx];
    assign in_range   = ({1'b0, r_node} < eff_n);
    assign issue_scan = i_cmd.scan_step && r_issuing && (r_ridx < eff_n_w);
    assign rd_flags   = r_rd_valid ? r_rd_data[33:32] : FLAG_NAMED;
    assign rd_id      = r_rd_valid ? r_rd_data[31:0] : 32'd0;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = {r_bank, r_ridx[NW-1:0]};
        if (i_cmd.scan_start) begin
            rd_en   = 1'b1;
            rd_addr = {cur_bank, node_idx};
        end else if (issue_scan) begin
            rd_en   = 1'b1;
        end
    end

    always_comb begin
        if (r_depart[r_bank] == COUNT_MAX) begin
            n_depart = COUNT_MAX;
        end else begin
            n_depart = r_depart[r_bank] + CNT_W'(1);
        end
    end

    assign o_sts.err       = !in_range || ((r_op == OP_NOTIFY) ? cur_inside : !cur_inside);
    assign o_sts.op_wait   = (r_op == OP_WAIT);
    assign o_sts.not_ready = (r_arrive[cur_bank] < eff_n_w);
    assign o_sts.scan_done = !r_issuing && !r_rd_own && !r_rd_scan;
    assign o_sts.mismatch  = r_mm;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_node  <= i_node;
            r_id    <= i_id;
            r_flags <= i_flags;
        end
        if (i_cmd.notify) begin
            r_mem[{cur_bank, node_idx}] <= {r_flags, r_id};
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (i_cmd.scan_step && r_rd_scan && rd_flags == FLAG_NAMED && !r_has_ref) begin
            r_ref <= rd_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg      <= CFG_RESET;
            r_arrive   <= '{default: '0};
            r_depart   <= '{default: '0};
            r_sticky   <= '0;
            r_phase    <= '0;
            r_inside   <= '0;
            r_vld      <= '0;
            r_rd_valid <= 1'b0;
            r_bank     <= 1'b0;
            r_ridx     <= '0;
            r_rd_own   <= 1'b0;
            r_rd_scan  <= 1'b0;
            r_issuing  <= 1'b0;
            r_mm       <= 1'b0;
            r_has_ref  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (rd_en) begin
                r_rd_valid <= r_vld[rd_addr];
            end
            if (i_cmd.notify) begin
                r_vld[{cur_bank, node_idx}] <= 1'b1;
                r_inside[node_idx] <= 1'b1;
                if (r_flags == FLAG_MISMATCH) begin
                    r_sticky[cur_bank] <= 1'b1;
                end
                if (r_arrive[cur_bank] != COUNT_MAX) begin
                    r_arrive[cur_bank] <= r_arrive[cur_bank] + CNT_W'(1);
                end
            end
            if (i_cmd.scan_start) begin
                r_bank    <= cur_bank;
                r_ridx    <= '0;
                r_rd_own  <= 1'b1;
                r_rd_scan <= 1'b0;
                r_issuing <= 1'b1;
                r_mm      <= r_sticky[cur_bank];
                r_has_ref <= 1'b0;
            end
            if (i_cmd.scan_step) begin
                r_rd_own  <= 1'b0;
                r_rd_scan <= issue_scan;
                if (issue_scan) begin
                    r_ridx <= r_ridx + CNT_W'(1);
                end else begin
                    r_issuing <= 1'b0;
                end
                if (r_rd_own && (rd_flags != r_flags || rd_id != r_id)) begin
                    r_mm <= 1'b1;
                end
                if (r_rd_scan && rd_flags == FLAG_NAMED) begin
                    if (!r_has_ref) begin
                        r_has_ref <= 1'b1;
                    end else if (rd_id != r_ref) begin
                        r_mm <= 1'b1;
                    end
                end
            end
            if (i_cmd.depart) begin
                r_inside[node_idx] <= 1'b0;
                r_phase[node_idx]  <= ~r_bank;
                if (n_depart >= eff_n_w) begin
                    r_arrive[r_bank] <= '0;
                    r_depart[r_bank] <= '0;
                    r_sticky[r_bank] <= 1'b0;
                end else begin
                    r_depart[r_bank] <= n_depart;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/nspb_ctrl.sv
// Barrier controller: state machine that sequences each request through
// the datapath and owns the result register. Uses nspb_pkg.
`default_nettype none

module nspb_ctrl
    import nspb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_s_valid,
    output logic      o_s_ready,
    input  wire logic i_m_ready,
    output logic      o_m_valid,
    output t_status   o_m_status,
    output t_cmd      o_cmd,
    input  wire t_sts i_sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DONE
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_status r_code;
    t_status n_code;
    logic    r_out_vld;
    t_status r_out_status;

    assign o_s_ready  = (r_state == S_IDLE);
    assign o_m_valid  = r_out_vld;
    assign o_m_status = r_out_status;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_code  = r_code;
        case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                if (i_sts.err) begin
                    n_code = ST_PROTOCOL;
                end else if (!i_sts.op_wait) begin
                    o_cmd.notify = 1'b1;
                    n_code       = ST_NOTIFIED;
                end else if (i_sts.not_ready) begin
                    n_code = ST_NOT_READY;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    o_cmd.depart = 1'b1;
                    n_code       = i_sts.mismatch ? ST_MISMATCH : ST_OK;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_vld || i_m_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_code       <= ST_OK;
            r_out_vld    <= 1'b0;
            r_out_status <= ST_OK;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
            if (r_state == S_DONE && (!r_out_vld || i_m_ready)) begin
                r_out_vld    <= 1'b1;
                r_out_status <= r_code;
            end else if (i_m_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/named_split_phase_barrier.sv
// Split-phase barrier top level: a notify, a not-ready answer or a protocol error passes through
// the load and execute states to the result register; a completed wait also passes through the
// one-entry-a-cycle scan of the flag and id memory over the n effective nodes.
// One request is in flight at a time: the next transfer is taken in the cycle after the result
// is registered, later while an earlier result is still unread.
// Synchronous active-low reset clears counters, phases and valid bits; uses nspb_pkg.
`default_nettype none

module named_split_phase_barrier
    import nspb_pkg::*;
#(
    parameter int NODES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [4:0]  i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // node [3:0], barrier_id [35:4], barrier_flags [37:36], zero fill
    input  wire logic [39:0] s_axis_tdata,
    // op
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // status [2:0], zero fill
    output logic [7:0]       m_axis_tdata
);

    t_cmd    cmd;
    t_sts    sts;
    t_status status;

    nspb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_valid  (s_axis_tvalid),
        .o_s_ready  (s_axis_tready),
        .i_m_ready  (m_axis_tready),
        .o_m_valid  (m_axis_tvalid),
        .o_m_status (status),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    nspb_dp #(
        .NODES (NODES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_op        (s_axis_tuser),
        .i_node      (s_axis_tdata[3:0]),
        .i_id        (s_axis_tdata[35:4]),
        .i_flags     (s_axis_tdata[37:36]),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

    assign m_axis_tdata = {5'd0, status};

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking bench for the split-phase barrier: random and directed notify and wait
// transfers are scored against a cycle-free model of the barrier kept inside the bench.
// Depends on nspb_pkg and named_split_phase_barrier.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import nspb_pkg::*;

    localparam int NODES = 16;
    localparam int CLK_PERIOD = 10;
    localparam int CYCLE_LIMIT = 500_000;
    localparam int SETTLE_CYCLES = NODES + 8;
    localparam int PHASE_ITEMS = 50;
    localparam int MAX_REPORTS = 100;

    localparam logic [1:0] FLAG_ANON        = 2'd1;
    localparam logic [1:0] FLAG_ANON_MARKED = 2'd3;

    typedef struct packed {
        logic        op;
        logic [3:0]  node;
        logic [31:0] id;
        logic [1:0]  flags;
    } req_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [4:0]  i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;

    // Model of the barrier state.
    logic [4:0]  count_reg;
    logic [5:0]  arrivals [2];
    logic [5:0]  departures [2];
    logic        sticky [2];
    logic [1:0]  flags_mem [2][NODES];
    logic [31:0] id_mem [2][NODES];
    logic        node_phase [NODES];
    logic        node_inside [NODES];

    req_t    req_q [$];
    t_status status_q [$];
    req_t    on_bus;
    int      in_flight = 0;
    int      items_sent = 0;
    int      results_checked = 0;
    int      fail_count = 0;
    int      status_tally [5] = '{default: 0};
    int      send_gap = 0;
    int      rcv_stall = 0;
    int      cycle_count = 0;
    int      perm [NODES];
    bit      burst = 1'b0;

    named_split_phase_barrier #(.NODES(NODES)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int active_nodes();
        int n;
        n = int'(count_reg);
        if (n == 0) n = 1;
        if (n > NODES) n = NODES;
        return n;
    endfunction

    function automatic t_status barrier_step(input req_t r);
        int          n;
        logic        b;
        logic [31:0] named_id;
        bit          named_seen;
        bit          bad;
        n = active_nodes();
        if (int'(r.node) >= n) return ST_PROTOCOL;
        b = node_phase[r.node];
        if (r.op == OP_NOTIFY) begin
            if (node_inside[r.node]) return ST_PROTOCOL;
            flags_mem[b][r.node] = r.flags;
            id_mem[b][r.node] = r.id;
            if (r.flags == FLAG_MISMATCH) sticky[b] = 1'b1;
            if (arrivals[b] != COUNT_MAX) arrivals[b] = arrivals[b] + 6'd1;
            node_inside[r.node] = 1'b1;
            return ST_NOTIFIED;
        end
        if (!node_inside[r.node]) return ST_PROTOCOL;
        if (arrivals[b] < n) return ST_NOT_READY;
        bad = sticky[b] || r.flags != flags_mem[b][r.node] || r.id != id_mem[b][r.node];
        named_seen = 1'b0;
        named_id = '0;
        for (int k = 0; k < n; k++) begin
            if (flags_mem[b][k] == FLAG_NAMED) begin
                if (!named_seen) begin
                    named_seen = 1'b1;
                    named_id = id_mem[b][k];
                end else if (id_mem[b][k] != named_id) begin
                    bad = 1'b1;
                end
            end
        end
        node_inside[r.node] = 1'b0;
        if (departures[b] != COUNT_MAX) departures[b] = departures[b] + 6'd1;
        if (departures[b] >= n) begin
            arrivals[b] = '0;
            departures[b] = '0;
            sticky[b] = 1'b0;
        end
        node_phase[r.node] = ~b;
        return bad ? ST_MISMATCH : ST_OK;
    endfunction

    function automatic bit quiescent();
        for (int k = 0; k < NODES; k++) begin
            if (node_inside[k] || node_phase[k]) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic send(input logic op, input int node, input logic [31:0] id,
                        input logic [1:0] flags);
        req_t r;
        r.op = op;
        r.node = node[3:0];
        r.id = id;
        r.flags = flags;
        req_q.push_back(r);
        in_flight++;
        items_sent++;
    endtask

    task automatic wait_idle();
        while (in_flight != 0 || status_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [4:0] value);
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        count_reg = value;
    endtask

    task automatic draw_perm(input int n);
        int i;
        int j;
        int t;
        for (i = 0; i < n; i++) perm[i] = i;
        for (i = n - 1; i > 0; i--) begin
            j = int'($urandom_range(0, i));
            t = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
    endtask

    task automatic send_noise();
        send(1'($urandom_range(0, 1)), int'($urandom_range(0, NODES - 1)), $urandom,
             2'($urandom_range(0, 3)));
    endtask

    // One barrier round: every participant outside notifies, then every participant
    // waits. Rounds that are not clean carry stray transfers, skipped steps and
    // corrupted waits.
    task automatic run_round(input bit clean);
        int          n;
        int          i;
        int          j;
        logic [31:0] round_id;
        logic [31:0] id;
        logic [1:0]  fl;
        logic [1:0]  want_flags [NODES];
        logic [31:0] want_id [NODES];
        logic        was_inside [NODES];
        wait_idle();
        n = active_nodes();
        round_id = $urandom;
        for (i = 0; i < n; i++) begin
            want_flags[i] = flags_mem[node_phase[i]][i];
            want_id[i] = id_mem[node_phase[i]][i];
            was_inside[i] = node_inside[i];
        end
        draw_perm(n);
        for (i = 0; i < n; i++) begin
            j = perm[i];
            if (!clean && $urandom_range(0, 9) == 0) send_noise();
            if (!was_inside[j] && (clean || $urandom_range(0, 19) != 0)) begin
                want_id[j] = ($urandom_range(0, 15) == 0) ? $urandom : round_id;
                case ($urandom_range(0, 19))
                    15, 16, 17: want_flags[j] = FLAG_ANON;
                    18: want_flags[j] = FLAG_MISMATCH;
                    19: want_flags[j] = FLAG_ANON_MARKED;
                    default: want_flags[j] = FLAG_NAMED;
                endcase
                send(OP_NOTIFY, j, want_id[j], want_flags[j]);
            end
        end
        draw_perm(n);
        for (i = 0; i < n; i++) begin
            j = perm[i];
            if (!clean && $urandom_range(0, 9) == 0) send_noise();
            if (clean || $urandom_range(0, 19) != 0) begin
                id = want_id[j];
                fl = want_flags[j];
                if (!clean && $urandom_range(0, 11) == 0) begin
                    if ($urandom_range(0, 1) == 1) id = id ^ (32'd1 << $urandom_range(0, 31));
                    else fl = 2'($urandom_range(0, 3));
                end
                send(OP_WAIT, j, id, fl);
            end
        end
    endtask

    task automatic settle_barrier();
        int d;
        d = 0;
        wait_idle();
        while (!quiescent() && d < 8) begin
            run_round(1'b1);
            wait_idle();
            d++;
        end
    endtask

    always @(posedge i_clk) begin : feeder
        req_t    nxt;
        t_status st;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                st = barrier_step(on_bus);
                status_q.push_back(st);
                status_tally[int'(st)]++;
                in_flight--;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (req_q.size() != 0) begin
                    nxt = req_q.pop_front();
                    on_bus <= nxt;
                    s_axis_tdata <= {2'b00, nxt.flags, nxt.id, nxt.node};
                    s_axis_tuser <= nxt.op;
                    s_axis_tvalid <= 1'b1;
                    send_gap = burst ? 0 : int'($urandom_range(0, 10));
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : scoreboard
        t_status want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rcv_stall = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_checked++;
                if (status_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $error("status: no result expected, got %0d", m_axis_tdata[2:0]);
                end else begin
                    want = status_q.pop_front();
                    if (m_axis_tdata[2:0] !== want) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $error("status: expected %0d (%s), got %0d",
                                   want, want.name(), m_axis_tdata[2:0]);
                    end
                end
                rcv_stall = burst ? 0 : int'($urandom_range(0, 10));
            end else if (rcv_stall != 0) begin
                rcv_stall--;
            end
            m_axis_tready <= (rcv_stall == 0);
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d transfers outstanding",
                     cycle_count, in_flight + status_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        int counts [11] = '{16, 1, 0, 31, 2, 7, 16, 4, 20, 12, 16};
        int p;
        int start_items;
        count_reg = CFG_RESET;
        for (int b = 0; b < 2; b++) begin
            arrivals[b] = '0;
            departures[b] = '0;
            sticky[b] = 1'b0;
            for (int k = 0; k < NODES; k++) begin
                flags_mem[b][k] = '0;
                id_mem[b][k] = '0;
            end
        end
        for (int k = 0; k < NODES; k++) begin
            node_phase[k] = 1'b0;
            node_inside[k] = 1'b0;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The reset count admits the top node.
        send(OP_WAIT, 15, 32'h0, FLAG_NAMED);
        send(OP_NOTIFY, 15, 32'hFFFF_FFFF, FLAG_ANON_MARKED);
        send(OP_WAIT, 15, 32'hFFFF_FFFF, FLAG_ANON_MARKED);
        settle_barrier();

        write_count(5'd3);
        send(OP_WAIT, 0, 32'h0, FLAG_NAMED);
        send(OP_NOTIFY, 0, 32'h0, FLAG_NAMED);
        send(OP_NOTIFY, 0, 32'h0, FLAG_NAMED);
        send(OP_WAIT, 0, 32'h0, FLAG_NAMED);
        send(OP_NOTIFY, 15, 32'hFFFF_FFFF, FLAG_ANON_MARKED);
        send(OP_NOTIFY, 1, 32'h0, FLAG_NAMED);
        send(OP_NOTIFY, 2, 32'hFFFF_FFFF, FLAG_ANON);
        send(OP_WAIT, 0, 32'h0, FLAG_NAMED);
        send(OP_WAIT, 1, 32'h0, FLAG_ANON);
        send(OP_WAIT, 2, 32'hFFFF_FFFF, FLAG_ANON);
        // A signalled mismatch sticks to the whole round.
        send(OP_NOTIFY, 0, 32'h5, FLAG_MISMATCH);
        send(OP_NOTIFY, 1, 32'h5, FLAG_NAMED);
        send(OP_NOTIFY, 2, 32'h5, FLAG_NAMED);
        send(OP_WAIT, 0, 32'h5, FLAG_MISMATCH);
        send(OP_WAIT, 1, 32'h5, FLAG_NAMED);
        send(OP_WAIT, 2, 32'h5, FLAG_NAMED);
        // Named ids disagree, and one wait brings the wrong id.
        send(OP_NOTIFY, 0, 32'h7, FLAG_ANON_MARKED);
        send(OP_NOTIFY, 1, 32'h7, FLAG_NAMED);
        send(OP_NOTIFY, 2, 32'h8, FLAG_NAMED);
        send(OP_WAIT, 2, 32'h8, FLAG_NAMED);
        send(OP_WAIT, 0, 32'h9, FLAG_ANON_MARKED);
        send(OP_WAIT, 1, 32'h7, FLAG_NAMED);

        for (p = 0; p < $size(counts); p++) begin
            settle_barrier();
            write_count(counts[p][4:0]);
            burst = (p % 3 == 2);
            start_items = items_sent;
            while (items_sent - start_items < PHASE_ITEMS) run_round(1'b0);
        end
        settle_barrier();
        burst = 1'b0;
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Checked %0d results from %0d requests over %0d node-count settings.",
                 results_checked, items_sent, $size(counts) + 2);
        $display("Outcomes: ok %0d, mismatch %0d, not ready %0d, notified %0d, protocol %0d.",
                 status_tally[ST_OK], status_tally[ST_MISMATCH], status_tally[ST_NOT_READY],
                 status_tally[ST_NOTIFIED], status_tally[ST_PROTOCOL]);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
